// ===== src/cfte_pkg.sv =====
// Shared types, codes and constants for the CFTABLE_ENTRY body parser.
package cfte_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int ChainMax = 8;

  localparam logic [CfgIdxW-1:0] CFG_MIN_IO_LENGTH     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IO_INTERFACE_CODE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ASSUMED_IO_OFFSET = 2'd2;

  localparam int FL_DEFAULT   = 0;
  localparam int FL_HAS_IF    = 1;
  localparam int FL_HAS_IO    = 2;
  localparam int FL_IO8       = 3;
  localparam int FL_IO16      = 4;
  localparam int FL_HAS_IRQ   = 5;
  localparam int FL_IRQ_LEVEL = 6;

  localparam logic [1:0] SCORE_NONE = 2'd0;
  localparam logic [1:0] SCORE_IO16 = 2'd1;
  localparam logic [1:0] SCORE_BEST = 2'd2;

  typedef enum logic [3:0] {
    PH_INDEX, PH_IFACE, PH_FEATURE, PH_POW_SEL, PH_POW_EXT, PH_TIM_SCALE,
    PH_TIM_EXT, PH_IO_FIRST, PH_IO_SIZES, PH_IO_WIN, PH_IRQ_INFO,
    PH_IRQ_MASK, PH_MEM_DESC, PH_MEM_WIN, PH_MISC, PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        entry_ok;
    logic [5:0]  config_index;
    logic [6:0]  entry_flags;
    logic [3:0]  interface_type;
    logic [4:0]  addr_lines;
    logic [4:0]  io_windows;
    logic [15:0] io_base;
    logic [15:0] io_length;
    logic [1:0]  score;
    logic [15:0] io_offset;
  } out_t;

  typedef struct packed {
    logic [5:0]  index;
    logic [6:0]  flags;
    logic [3:0]  iface;
    logic [4:0]  lines;
    logic [4:0]  nwin;
    logic [15:0] base;
    logic [15:0] len;
  } entry_t;

  typedef struct packed {
    logic [15:0] min_io_length;
    logic [3:0]  io_interface_code;
    logic [15:0] assumed_io_offset;
  } cfg_t;

endpackage

// ===== src/cfte_parse.sv =====
// Byte-at-a-time section walker holding the parse state and decoded fields.
module cfte_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  cfte_pkg::in_t   beat,
  output cfte_pkg::entry_t entry_next,
  output logic            done_next
);
  import cfte_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  feat;
    logic [1:0]  pleft;
    logic [6:0]  sel;
    logic [3:0]  guard;
    logic [4:0]  wcnt;
    logic [3:0]  fbc;
    logic [7:0]  fsz;
    logic [15:0] bacc;
    logic [32:0] lacc;
  } pst_t;

  pst_t   st, st_next;
  entry_t ent, ent_next;

  function automatic pst_t enter_from(pst_t s, logic [2:0] stage);
    pst_t r;
    r = s;
    if (stage == 3'd0) r.pleft = s.feat[1:0];
    priority if (stage == 3'd0 && s.feat[1:0] != 2'd0) r.phase = PH_POW_SEL;
    else if (stage <= 3'd1 && s.feat[2]) r.phase = PH_TIM_SCALE;
    else if (stage <= 3'd2 && s.feat[3]) r.phase = PH_IO_FIRST;
    else if (stage <= 3'd3 && s.feat[4]) r.phase = PH_IRQ_INFO;
    else if (stage <= 3'd4 && s.feat[6:5] == 2'b11) r.phase = PH_MEM_DESC;
    else if (stage <= 3'd4 && s.feat[6:5] != 2'b00) begin
      r.fsz   = (s.feat[6:5] == 2'b01) ? 8'd2 : 8'd4;
      r.wcnt  = 5'd1;
      r.fbc   = 4'd0;
      r.phase = PH_MEM_WIN;
    end else if (stage <= 3'd5 && s.feat[7]) begin
      r.guard = 4'd0;
      r.phase = PH_MISC;
    end else r.phase = PH_DONE;
    return r;
  endfunction

  function automatic pst_t power_done(pst_t s);
    pst_t r;
    r = s;
    r.pleft = s.pleft - 2'd1;
    if (r.pleft != 2'd0) r.phase = PH_POW_SEL;
    else r = enter_from(r, 3'd1);
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic        chain_end;
    logic [3:0]  guard_inc;
    logic [2:0]  bsz, lsz;
    logic [4:0]  pos1;
    logic [1:0]  k;
    logic [1:0]  mlsz, masz;
    b         = beat.body_byte;
    st_next   = st;
    ent_next  = ent;
    guard_inc = st.guard + 4'd1;
    chain_end = !b[7] || (guard_inc >= 4'(ChainMax));
    bsz       = 3'd0;
    lsz       = 3'd0;
    pos1      = 5'(st.fbc) + 5'd1;
    k         = 2'd0;
    mlsz      = b[4:3];
    masz      = b[6:5];
    unique case (st.phase)
      PH_INDEX: begin
        ent_next.index = b[5:0];
        if (b[6]) ent_next.flags[FL_DEFAULT] = 1'b1;
        if (b[7]) begin
          ent_next.flags[FL_HAS_IF] = 1'b1;
          st_next.phase = PH_IFACE;
        end else st_next.phase = PH_FEATURE;
      end
      PH_IFACE: begin
        ent_next.iface = b[3:0];
        st_next.phase  = PH_FEATURE;
      end
      PH_FEATURE: begin
        st_next.feat = b;
        st_next = enter_from(st_next, 3'd0);
      end
      PH_POW_SEL: begin
        st_next.sel   = b[6:0];
        st_next.guard = 4'd0;
        if (b[6:0] != 7'd0) st_next.phase = PH_POW_EXT;
        else st_next = power_done(st_next);
      end
      PH_POW_EXT: begin
        st_next.guard = chain_end ? 4'd0 : guard_inc;
        if (chain_end) begin
          st_next.sel = st.sel & (st.sel - 7'd1);
          if (st_next.sel == 7'd0) st_next = power_done(st_next);
        end
      end
      PH_TIM_SCALE: begin
        st_next.sel   = {4'd0, b[7:5] != 3'b111, b[4:2] != 3'b111, b[1:0] != 2'b11};
        st_next.guard = 4'd0;
        if (st_next.sel != 7'd0) st_next.phase = PH_TIM_EXT;
        else st_next = enter_from(st_next, 3'd2);
      end
      PH_TIM_EXT: begin
        st_next.guard = chain_end ? 4'd0 : guard_inc;
        if (chain_end) begin
          st_next.sel = st.sel & (st.sel - 7'd1);
          if (st_next.sel == 7'd0) st_next = enter_from(st_next, 3'd2);
        end
      end
      PH_IO_FIRST: begin
        ent_next.flags[FL_HAS_IO] = 1'b1;
        ent_next.lines = b[4:0];
        if (b[5]) ent_next.flags[FL_IO8] = 1'b1;
        if (b[6]) ent_next.flags[FL_IO16] = 1'b1;
        if (!b[7]) begin
          ent_next.nwin = 5'd1;
          ent_next.base = 16'd0;
          ent_next.len  = b[4] ? 16'hffff : (16'd1 << b[3:0]);
          st_next = enter_from(st_next, 3'd3);
        end else st_next.phase = PH_IO_SIZES;
      end
      PH_IO_SIZES: begin
        bsz = (b[5:4] == 2'd3) ? 3'd4 : {1'b0, b[5:4]};
        lsz = (b[7:6] == 2'd3) ? 3'd4 : {1'b0, b[7:6]};
        ent_next.nwin = 5'(b[3:0]) + 5'd1;
        ent_next.base = 16'd0;
        ent_next.len  = 16'd1;
        st_next.fsz   = {1'b0, lsz, 1'b0, bsz};
        st_next.wcnt  = 5'd0;
        st_next.fbc   = 4'd0;
        st_next.bacc  = 16'd0;
        st_next.lacc  = 33'd1;
        if (bsz == 3'd0 && lsz == 3'd0) st_next = enter_from(st_next, 3'd3);
        else st_next.phase = PH_IO_WIN;
      end
      PH_IO_WIN: begin
        bsz = st.fsz[2:0];
        lsz = st.fsz[6:4];
        if (st.fbc < 4'(bsz)) begin
          if (st.fbc[1:0] == 2'd0) st_next.bacc[7:0] = b;
          else if (st.fbc[1:0] == 2'd1) st_next.bacc[15:8] = b;
        end else begin
          k = st.fbc[1:0] - bsz[1:0];
          st_next.lacc = st.lacc + (33'(b) << {k, 3'b000});
        end
        if (st.wcnt == 5'd0) begin
          ent_next.base = st_next.bacc;
          ent_next.len  = (|st_next.lacc[32:16]) ? 16'hffff : st_next.lacc[15:0];
        end
        if (pos1 >= 5'(bsz) + 5'(lsz)) begin
          st_next.fbc  = 4'd0;
          st_next.bacc = 16'd0;
          st_next.lacc = 33'd1;
          st_next.wcnt = st.wcnt + 5'd1;
          if (st_next.wcnt >= ent.nwin) st_next = enter_from(st_next, 3'd3);
        end else st_next.fbc = pos1[3:0];
      end
      PH_IRQ_INFO: begin
        ent_next.flags[FL_HAS_IRQ] = 1'b1;
        if (b[5]) ent_next.flags[FL_IRQ_LEVEL] = 1'b1;
        if (b[4]) begin
          st_next.fbc   = 4'd0;
          st_next.phase = PH_IRQ_MASK;
        end else st_next = enter_from(st_next, 3'd4);
      end
      PH_IRQ_MASK: begin
        st_next.fbc = st.fbc + 4'd1;
        if (st_next.fbc >= 4'd2) begin
          st_next.fbc = 4'd0;
          st_next = enter_from(st_next, 3'd4);
        end
      end
      PH_MEM_DESC: begin
        st_next.fsz  = 8'(mlsz) + (b[7] ? 8'({masz, 1'b0}) : 8'(masz));
        st_next.wcnt = 5'(b[2:0]) + 5'd1;
        st_next.fbc  = 4'd0;
        if (st_next.fsz == 8'd0) st_next = enter_from(st_next, 3'd5);
        else st_next.phase = PH_MEM_WIN;
      end
      PH_MEM_WIN: begin
        st_next.fbc = st.fbc + 4'd1;
        if (8'(st_next.fbc) >= st.fsz) begin
          st_next.fbc  = 4'd0;
          st_next.wcnt = st.wcnt - 5'd1;
          if (st_next.wcnt == 5'd0) st_next = enter_from(st_next, 3'd5);
        end
      end
      PH_MISC: begin
        st_next.guard = chain_end ? 4'd0 : guard_inc;
        if (chain_end) st_next = enter_from(st_next, 3'd6);
      end
      PH_DONE: begin
        st_next = st;
      end
      default: st_next = st;
    endcase
    done_next  = (st_next.phase == PH_DONE);
    entry_next = ent_next;
  end

  // Clear all parse state on reset and after the last beat of a body.
  always_ff @(posedge clk) begin
    if (rst || (fire && beat.last_byte)) begin
      st  <= '{phase: PH_INDEX, feat: 8'd0, pleft: 2'd0, sel: 7'd0, guard: 4'd0,
               wcnt: 5'd0, fbc: 4'd0, fsz: 8'd0, bacc: 16'd0, lacc: 33'd1};
      ent <= '0;
    end else if (fire) begin
      st  <= st_next;
      ent <= ent_next;
    end
  end

endmodule

// ===== src/cfte_result.sv =====
// Two-stage result path: entry capture, then score and offset into the output register.
module cfte_result (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cfte_pkg::entry_t entry,
  input  logic             ok,
  input  cfte_pkg::cfg_t   cfg,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output cfte_pkg::out_t   out_data
);
  import cfte_pkg::*;

  logic   hold_valid;
  entry_t hold;
  logic   hold_ok;
  logic   out_ready, hold_ready;
  logic [1:0]  score;
  logic [15:0] offset, mask;

  assign out_ready  = !out_valid || !out_stall;
  assign hold_ready = !hold_valid || out_ready;
  assign ready      = hold_ready;

  always_comb begin
    mask = hold.lines[4] ? 16'hffff : ((16'd1 << hold.lines[3:0]) - 16'd1);
    priority if (!hold.flags[FL_HAS_IO]) score = SCORE_NONE;
    else if (hold.flags[FL_HAS_IF] && hold.iface != cfg.io_interface_code)
      score = SCORE_NONE;
    else if (hold.nwin == 5'd0 || hold.len < cfg.min_io_length) score = SCORE_NONE;
    else if (hold.flags[FL_IO16] && !hold.flags[FL_IO8]) score = SCORE_IO16;
    else score = SCORE_BEST;
    priority if (!hold.flags[FL_HAS_IO] || hold.lines == 5'd0 || hold.base == 16'd0)
      offset = cfg.assumed_io_offset;
    else if (((cfg.assumed_io_offset ^ hold.base) & mask) == 16'd0)
      offset = cfg.assumed_io_offset;
    else offset = hold.base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (hold_ready) hold_valid <= push;
      if (out_ready) out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_ready && push) begin
      hold    <= entry;
      hold_ok <= ok;
    end
    if (out_ready && hold_valid) begin
      out_data.entry_ok       <= hold_ok;
      out_data.config_index   <= hold.index;
      out_data.entry_flags    <= hold.flags;
      out_data.interface_type <= hold.iface;
      out_data.addr_lines     <= hold.lines;
      out_data.io_windows     <= hold.nwin;
      out_data.io_base        <= hold.base;
      out_data.io_length      <= hold.len;
      out_data.score          <= score;
      out_data.io_offset      <= offset;
    end
  end

endmodule

// ===== src/cftable_entry_parser.sv =====
// Top level of the CFTABLE_ENTRY body parser: config registers and handshake.
// A last beat's result is registered in the capture stage, then in the output register, and shows on out_valid.
// Throughput: one beat per cycle unless stalled; the section walker updates once per accepted beat.
// Beats are stalled only while both the capture stage and output register are full.
// Reset (rst, synchronous): parse restarts at the index byte, pipeline empties,
// config returns to min_io_length 16, io_interface_code 1, assumed_io_offset 768.
module cftable_entry_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cfte_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cfte_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [cfte_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cfte_pkg::CfgDataW-1:0]   cfg_data
);
  import cfte_pkg::*;

  cfg_t   cfg;
  entry_t entry_next;
  logic   done_next;
  logic   ready;
  logic   fire;

  // Accept a beat whenever the capture stage can take a result.
  assign in_stall = !ready;
  assign fire     = in_valid && ready;

  // Configuration: plain register writes, unknown indexes dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_io_length     <= 16'd16;
      cfg.io_interface_code <= 4'd1;
      cfg.assumed_io_offset <= 16'd768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_IO_LENGTH:     cfg.min_io_length     <= cfg_data;
        CFG_IO_INTERFACE_CODE: cfg.io_interface_code <= cfg_data[3:0];
        CFG_ASSUMED_IO_OFFSET: cfg.assumed_io_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Walk sections; present the post-beat entry for capture.
  cfte_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .beat       (in_data),
    .entry_next (entry_next),
    .done_next  (done_next)
  );

  // Capture on the last beat, then score and resolve the offset.
  cfte_result u_result (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && in_data.last_byte),
    .entry     (entry_next),
    .ok        (done_next),
    .cfg       (cfg),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== verif/cftable_entry_checker.sv =====
// Result checker for the CFTABLE_ENTRY parser: predicts each tuple result and compares it.
module cftable_entry_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  cfte_pkg::in_t                 in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  cfte_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [cfte_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cfte_pkg::CfgDataW-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfte_pkg::*;

  cfg_t        regs;
  phase_t      phase;
  logic [7:0]  feat;
  logic [1:0]  pow_left;
  logic [7:0]  sel;
  logic [3:0]  guard;
  logic [4:0]  wins;
  logic [3:0]  fbytes;
  logic [7:0]  sizes;
  logic [31:0] base_acc;
  logic [32:0] len_acc;
  entry_t      ent;
  logic        done;
  out_t        results_due[$];

  task automatic restart_entry();
    phase = PH_INDEX; feat = '0; pow_left = '0; sel = '0; guard = '0;
    wins = '0; fbytes = '0; sizes = '0; base_acc = '0; len_acc = 33'd1;
    ent = '0; done = 1'b0;
  endtask

  function automatic logic chain_end(logic [7:0] b);
    guard = guard + 4'd1;
    if (!b[7] || guard >= ChainMax) begin
      guard = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic next_section(int stage);
    for (int s = stage; s <= 5; s++) begin
      case (s)
        0: begin
          pow_left = feat[1:0];
          if (pow_left != 0) begin phase = PH_POW_SEL; return; end
        end
        1: if (feat[2]) begin phase = PH_TIM_SCALE; return; end
        2: if (feat[3]) begin phase = PH_IO_FIRST; return; end
        3: if (feat[4]) begin phase = PH_IRQ_INFO; return; end
        4: begin
          if (feat[6:5] == 2'b11) begin phase = PH_MEM_DESC; return; end
          if (feat[6:5] != 2'b00) begin
            sizes = (feat[6:5] == 2'b01) ? 8'd2 : 8'd4;
            wins = 5'd1; fbytes = '0; phase = PH_MEM_WIN; return;
          end
        end
        default: if (feat[7]) begin guard = '0; phase = PH_MISC; return; end
      endcase
    end
    phase = PH_DONE;
    done = 1'b1;
  endtask

  task automatic power_step();
    pow_left = pow_left - 2'd1;
    if (pow_left != 0) phase = PH_POW_SEL;
    else next_section(1);
  endtask

  task automatic walk_byte(logic [7:0] b);
    int bsz, lsz, pos;
    case (phase)
      PH_INDEX: begin
        ent.index = b[5:0];
        if (b[6]) ent.flags[FL_DEFAULT] = 1'b1;
        if (b[7]) begin ent.flags[FL_HAS_IF] = 1'b1; phase = PH_IFACE; end
        else phase = PH_FEATURE;
      end
      PH_IFACE: begin ent.iface = b[3:0]; phase = PH_FEATURE; end
      PH_FEATURE: begin feat = b; next_section(0); end
      PH_POW_SEL: begin
        sel = {1'b0, b[6:0]}; guard = '0;
        if (sel != 0) phase = PH_POW_EXT;
        else power_step();
      end
      PH_POW_EXT:
        if (chain_end(b)) begin
          sel = sel & (sel - 8'd1);
          if (sel == 0) power_step();
        end
      PH_TIM_SCALE: begin
        sel = '0;
        if (b[1:0] != 2'b11) sel[0] = 1'b1;
        if (b[4:2] != 3'b111) sel[1] = 1'b1;
        if (b[7:5] != 3'b111) sel[2] = 1'b1;
        guard = '0;
        if (sel != 0) phase = PH_TIM_EXT;
        else next_section(2);
      end
      PH_TIM_EXT:
        if (chain_end(b)) begin
          sel = sel & (sel - 8'd1);
          if (sel == 0) next_section(2);
        end
      PH_IO_FIRST: begin
        ent.flags[FL_HAS_IO] = 1'b1;
        ent.lines = b[4:0];
        if (b[5]) ent.flags[FL_IO8] = 1'b1;
        if (b[6]) ent.flags[FL_IO16] = 1'b1;
        if (!b[7]) begin
          ent.nwin = 5'd1; ent.base = '0;
          ent.len = (ent.lines >= 16) ? 16'hffff : 16'(32'd1 << ent.lines);
          next_section(3);
        end else phase = PH_IO_SIZES;
      end
      PH_IO_SIZES: begin
        bsz = b[5:4]; lsz = b[7:6];
        if (bsz == 3) bsz = 4;
        if (lsz == 3) lsz = 4;
        ent.nwin = {1'b0, b[3:0]} + 5'd1;
        ent.base = '0; ent.len = 16'd1;
        sizes = 8'(bsz | (lsz << 4));
        wins = '0; fbytes = '0; base_acc = '0; len_acc = 33'd1;
        if (bsz + lsz == 0) next_section(3);
        else phase = PH_IO_WIN;
      end
      PH_IO_WIN: begin
        bsz = sizes[3:0]; lsz = sizes[7:4]; pos = fbytes;
        if (pos < bsz) base_acc = base_acc | (32'(b) << (8 * (pos & 3)));
        else len_acc = len_acc + (33'(b) << (8 * ((pos - bsz) & 3)));
        if (wins == 0) begin
          ent.base = base_acc[15:0];
          ent.len = (len_acc > 33'hffff) ? 16'hffff : len_acc[15:0];
        end
        if (pos + 1 >= bsz + lsz) begin
          fbytes = '0; base_acc = '0; len_acc = 33'd1;
          wins = wins + 5'd1;
          if (wins >= ent.nwin) next_section(3);
        end else fbytes = 4'(pos + 1);
      end
      PH_IRQ_INFO: begin
        ent.flags[FL_HAS_IRQ] = 1'b1;
        if (b[5]) ent.flags[FL_IRQ_LEVEL] = 1'b1;
        if (b[4]) begin fbytes = '0; phase = PH_IRQ_MASK; end
        else next_section(4);
      end
      PH_IRQ_MASK: begin
        fbytes = fbytes + 4'd1;
        if (fbytes >= 2) begin fbytes = '0; next_section(4); end
      end
      PH_MEM_DESC: begin
        sizes = 8'(b[4:3] + b[6:5] * (b[7] ? 2 : 1));
        wins = {2'b0, b[2:0]} + 5'd1;
        fbytes = '0;
        if (sizes == 0) next_section(5);
        else phase = PH_MEM_WIN;
      end
      PH_MEM_WIN: begin
        fbytes = fbytes + 4'd1;
        if (fbytes >= sizes) begin
          fbytes = '0; wins = wins - 5'd1;
          if (wins == 0) next_section(5);
        end
      end
      PH_MISC: if (chain_end(b)) next_section(6);
      default: ;
    endcase
  endtask

  function automatic out_t entry_result();
    out_t r;
    logic [15:0] mask;
    r.entry_ok = done;
    r.config_index = ent.index;
    r.entry_flags = ent.flags;
    r.interface_type = ent.iface;
    r.addr_lines = ent.lines;
    r.io_windows = ent.nwin;
    r.io_base = ent.base;
    r.io_length = ent.len;
    if (!ent.flags[FL_HAS_IO]) r.score = SCORE_NONE;
    else if (ent.flags[FL_HAS_IF] && ent.iface != regs.io_interface_code) r.score = SCORE_NONE;
    else if (ent.nwin == 0 || ent.len < regs.min_io_length) r.score = SCORE_NONE;
    else if (ent.flags[FL_IO16] && !ent.flags[FL_IO8]) r.score = SCORE_IO16;
    else r.score = SCORE_BEST;
    if (!ent.flags[FL_HAS_IO] || ent.lines == 0 || ent.base == 0) begin
      r.io_offset = regs.assumed_io_offset;
    end else begin
      mask = (ent.lines >= 16) ? 16'hffff : 16'((32'd1 << ent.lines) - 1);
      r.io_offset = (((regs.assumed_io_offset ^ ent.base) & mask) == 0) ?
                    regs.assumed_io_offset : ent.base;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      regs.min_io_length = 16'd16;
      regs.io_interface_code = 4'd1;
      regs.assumed_io_offset = 16'd768;
      restart_entry();
      results_due.delete();
      fail_count = 0;
    end else begin
      // Compare a result beat with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data.config_index), 0);
        end else begin
          want = results_due.pop_front();
          if (out_data.entry_ok != want.entry_ok)
            report_mismatch("entry_ok", 32'(out_data.entry_ok), 32'(want.entry_ok));
          if (out_data.config_index != want.config_index)
            report_mismatch("config_index", 32'(out_data.config_index), 32'(want.config_index));
          if (out_data.entry_flags != want.entry_flags)
            report_mismatch("entry_flags", 32'(out_data.entry_flags), 32'(want.entry_flags));
          if (out_data.interface_type != want.interface_type)
            report_mismatch("interface_type", 32'(out_data.interface_type),
                            32'(want.interface_type));
          if (out_data.addr_lines != want.addr_lines)
            report_mismatch("addr_lines", 32'(out_data.addr_lines), 32'(want.addr_lines));
          if (out_data.io_windows != want.io_windows)
            report_mismatch("io_windows", 32'(out_data.io_windows), 32'(want.io_windows));
          if (out_data.io_base != want.io_base)
            report_mismatch("io_base", 32'(out_data.io_base), 32'(want.io_base));
          if (out_data.io_length != want.io_length)
            report_mismatch("io_length", 32'(out_data.io_length), 32'(want.io_length));
          if (out_data.score != want.score)
            report_mismatch("score", 32'(out_data.score), 32'(want.score));
          if (out_data.io_offset != want.io_offset)
            report_mismatch("io_offset", 32'(out_data.io_offset), 32'(want.io_offset));
        end
      end
      if (in_valid && !in_stall) begin
        if (!done) walk_byte(in_data.body_byte);
        if (in_data.last_byte) begin
          results_due.push_back(entry_result());
          restart_entry();
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_IO_LENGTH:     regs.min_io_length = cfg_data;
          CFG_IO_INTERFACE_CODE: regs.io_interface_code = cfg_data[3:0];
          CFG_ASSUMED_IO_OFFSET: regs.assumed_io_offset = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count = results_due.size();
  end
endmodule

// ===== verif/tb_cftable_entry_parser.sv =====
// Testbench top for the CFTABLE_ENTRY parser: stimulus, stalls and verdict.
module tb_cftable_entry_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import cfte_pkg::*;

  localparam int CycleLimit = 400000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  in_t                 in_data;
  logic                out_valid;
  logic                out_stall;
  out_t                out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  fail_count;
  int                  pending_count;
  int                  cycles;
  int                  beats_sent;
  bit                  calm_tail;   // no idling on either side near the end
  bit                  long_hold;   // receiver holds off for a long stretch

  cftable_entry_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cftable_entry_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if it runs far past any sane length.
  always @(posedge clk) begin
    if (rst) cycles <= 0;
    else cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off, none in the tail.
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
        @(negedge clk);
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Offer one beat, hold it until accepted; idle gaps come before it.
  task automatic send_beat(logic [7:0] b, logic last);
    if (!calm_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{body_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_body(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Append a continuation chain: mostly short, sometimes runaway.
  function automatic void add_chain(ref logic [7:0] q[$]);
    int n;
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) q.push_back({i < n - 1, 7'($urandom_range(0, 127))});
  endfunction

  // Build a well-formed body whose sections follow a random feature byte.
  function automatic void build_entry(ref logic [7:0] q[$]);
    logic [7:0] idx, feat, d;
    int bsz, lsz, nw, msz;
    idx = rnd8();
    q.push_back(idx);
    if (idx[7]) q.push_back($urandom_range(0, 3) == 0 ? rnd8() :
                            {4'($urandom_range(0, 15)), 4'd1});
    feat = rnd8();
    q.push_back(feat);
    for (int p = 0; p < feat[1:0]; p++) begin
      d = {1'($urandom_range(0, 1)),
           7'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 127))};
      q.push_back(d);
      for (int k = 0; k < $countones(d[6:0]); k++) add_chain(q);
    end
    if (feat[2]) begin
      d = rnd8();
      q.push_back(d);
      if (d[1:0] != 2'b11) add_chain(q);
      if (d[4:2] != 3'b111) add_chain(q);
      if (d[7:5] != 3'b111) add_chain(q);
    end
    if (feat[3]) begin
      d = rnd8();
      q.push_back(d);
      if (d[7]) begin
        d = rnd8();
        if ($urandom_range(0, 1)) d[3:0] = 4'($urandom_range(0, 2));
        q.push_back(d);
        bsz = d[5:4] == 3 ? 4 : d[5:4];
        lsz = d[7:6] == 3 ? 4 : d[7:6];
        nw = d[3:0] + 1;
        for (int w = 0; w < nw * (bsz + lsz); w++) q.push_back(rnd8());
      end
    end
    if (feat[4]) begin
      d = rnd8();
      q.push_back(d);
      if (d[4]) begin q.push_back(rnd8()); q.push_back(rnd8()); end
    end
    if (feat[6:5] == 2'b11) begin
      d = rnd8();
      q.push_back(d);
      msz = d[4:3] + d[6:5] * (d[7] ? 2 : 1);
      for (int w = 0; w < (d[2:0] + 1) * msz; w++) q.push_back(rnd8());
    end else if (feat[6:5] != 2'b00) begin
      for (int w = 0; w < (feat[6:5] == 2'b01 ? 2 : 4); w++) q.push_back(rnd8());
    end
    if (feat[7]) add_chain(q);
  endfunction

  task automatic random_phase(int beats);
    logic [7:0] q[$];
    int cut;
    int target;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      q.delete();
      case ($urandom_range(0, 9))
        0: begin
          // Noise body of random bytes.
          repeat ($urandom_range(1, 12)) q.push_back(rnd8());
        end
        1, 2: begin
          // Truncated body.
          build_entry(q);
          cut = $urandom_range(1, q.size());
          while (q.size() > cut) void'(q.pop_back());
        end
        3: begin
          // Trailing bytes past the end of the parse.
          build_entry(q);
          repeat ($urandom_range(1, 4)) q.push_back(rnd8());
        end
        default: build_entry(q);
      endcase
      send_body(q);
    end
  endtask

  initial begin
    beats_sent = 0;
    calm_tail = 1'b0;
    long_hold = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_IO_LENGTH;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed bodies at reset settings.
    send_body('{8'h00, 8'h00});                           // no sections
    send_body('{8'hff, 8'hff, 8'h00});                    // interface byte, no sections
    send_body('{8'hc1, 8'h01, 8'h08, 8'h6a});             // io, no ranges
    send_body('{8'h41, 8'h08, 8'hff});                    // 31 lines, ranges cut
    send_body('{8'h01, 8'h08, 8'h8a, 8'h80});             // ranges, no base field, cut
    send_body('{8'h02, 8'h08, 8'hea, 8'hff, 8'h00, 8'h03, 8'h10, 8'h00,
                8'h00, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00});   // 4 byte fields
    send_body('{8'h03, 8'h08, 8'hca, 8'h61});             // cut after size byte
    send_body('{8'h04, 8'h08, 8'haa, 8'h5f, 8'h00});      // cut mid window
    send_body('{8'h05, 8'h08, 8'h8a, 8'h5f, 8'h00, 8'h03, 8'h1f}); // 16 windows, cut
    send_body('{8'h06, 8'h01, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                8'hff, 8'hff, 8'hff, 8'h00});             // runaway chain
    send_body('{8'h07, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00}); // timing
    send_body('{8'h08, 8'h04, 8'hff});                    // timing, no ext
    send_body('{8'h09, 8'h30, 8'h30, 8'hff, 8'hff, 8'h11});  // irq mask, short memory cut
    send_body('{8'h0a, 8'h60, 8'hff, 8'h01});             // memory descriptor, cut
    send_body('{8'h0b, 8'h20, 8'h01, 8'h02, 8'h03, 8'h04});  // short memory
    send_body('{8'h0c, 8'h80, 8'h80, 8'h80, 8'h01});      // misc chain
    send_body('{8'h8d, 8'h05, 8'h08, 8'h50, 8'h00});      // wrong interface, io16
    drain();

    // Several register settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_MIN_IO_LENGTH, 16'h0000);
          write_reg(CFG_IO_INTERFACE_CODE, 4'd0);
          write_reg(CFG_ASSUMED_IO_OFFSET, 16'h0000);
        end
        1: begin
          write_reg(CFG_MIN_IO_LENGTH, 16'hffff);
          write_reg(CFG_IO_INTERFACE_CODE, 4'd15);
          write_reg(CFG_ASSUMED_IO_OFFSET, 16'hffff);
        end
        5: begin
          write_reg(CFG_MIN_IO_LENGTH, 16'd16);
          write_reg(CFG_IO_INTERFACE_CODE, 4'd1);
          write_reg(CFG_ASSUMED_IO_OFFSET, 16'h0300);
        end
        default: begin
          write_reg(CFG_MIN_IO_LENGTH, 16'($urandom_range(0, 64)));
          write_reg(CFG_IO_INTERFACE_CODE, 4'($urandom_range(0, 15)));
          write_reg(CFG_ASSUMED_IO_OFFSET, 16'($urandom_range(0, 65535)));
        end
      endcase
      if (ph == 2) long_hold = 1'b1;   // fill the block while the receiver holds off
      if (ph == 5) calm_tail = 1'b1;
      random_phase(230);
      drain();
    end

    // Let the pipeline settle, with a bound.
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== cftable_entry_parser.f =====
src/cfte_pkg.sv
src/cfte_parse.sv
src/cfte_result.sv
src/cftable_entry_parser.sv
verif/cftable_entry_checker.sv
verif/tb_cftable_entry_parser.sv
